>>> rtl/obb_pkg.sv
// obb_pkg: shared widths and constants for the oriented-box overlap test
// no dependencies
`default_nettype none
package obb_pkg;
   localparam int COORD_W = 20;
   localparam int AXIS_W = 16;
   localparam int CTR_BITS = 60;
   localparam int AXV_BITS = 48;
   localparam int SEP_W = 4;
   localparam logic [SEP_W-1:0] SEP_NONE = 4'd0;
endpackage
`default_nettype wire

>>> rtl/obb_overlap_separating_axis_test.sv
// obb_overlap_separating_axis_test: 15-axis oriented-box overlap test, pipelined
// depends on obb_pkg
//
// channel | valid     | ready     | payload
// req     | req_valid | req_ready | a_*/b_* box fields
// rsp     | rsp_valid | rsp_ready | overlap, separating_axis
//
// one item per cycle sustained while the output register is not stalled
// stages: products, dots/offsets, rounding, projections, sums, compares, output
// the whole pipe advances when the output register is empty or taken
// reset clears all valid bits; payload registers are not reset
`default_nettype none
module obb_overlap_separating_axis_test #(
   parameter int COORD_WIDTH = obb_pkg::COORD_W,
   parameter int AXIS_WIDTH = obb_pkg::AXIS_W
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic [obb_pkg::CTR_BITS-1:0] req_a_center,
   input  wire logic [obb_pkg::AXV_BITS-1:0] req_a_axis_x,
   input  wire logic [obb_pkg::AXV_BITS-1:0] req_a_axis_y,
   input  wire logic [obb_pkg::AXV_BITS-1:0] req_a_axis_z,
   input  wire logic [obb_pkg::CTR_BITS-1:0] req_a_half,
   input  wire logic [obb_pkg::CTR_BITS-1:0] req_b_center,
   input  wire logic [obb_pkg::AXV_BITS-1:0] req_b_axis_x,
   input  wire logic [obb_pkg::AXV_BITS-1:0] req_b_axis_y,
   input  wire logic [obb_pkg::AXV_BITS-1:0] req_b_axis_z,
   input  wire logic [obb_pkg::CTR_BITS-1:0] req_b_half,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic      rsp_overlap,
   output logic [obb_pkg::SEP_W-1:0] rsp_separating_axis
);
   import obb_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int AW = AXIS_WIDTH;
   localparam int FR = AW - 2;
   localparam int PW = 2*AW;           // axis product
   localparam int SW = 2*AW + 2;       // dot sum
   localparam int RW = AW + 3;         // rounded r (signed)
   localparam int DW = CW + 1;         // offset
   localparam int TPW = DW + AW;       // offset product
   localparam int TW = TPW + 2;        // t
   localparam int HW = CW + 1;         // signed half
   localparam int HPW = HW + RW;       // half * ar
   localparam int QPW = TW + RW;       // t * r
   localparam int QW = QPW + 2;        // projections
   localparam int CMPW = QW + FR + 4;  // compare width
   localparam int NS = 7;

   logic [NS-1:0] vld_ff;
   logic adv;
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // stage 1: products
   logic signed [AW-1:0] axa [3][3], axb [3][3];
   logic signed [CW-1:0] ca [3], cb [3];
   logic signed [PW-1:0] p1_in [3][3][3], p1_ff [3][3][3];
   logic signed [TPW-1:0] tp1_in [3][3], tp1_ff [3][3];
   logic [CW-1:0] ha1_ff [3], hb1_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ca[i] = req_a_center[i*CW +: CW];
         cb[i] = req_b_center[i*CW +: CW];
         axa[0][i] = req_a_axis_x[i*AW +: AW];
         axa[1][i] = req_a_axis_y[i*AW +: AW];
         axa[2][i] = req_a_axis_z[i*AW +: AW];
         axb[0][i] = req_b_axis_x[i*AW +: AW];
         axb[1][i] = req_b_axis_y[i*AW +: AW];
         axb[2][i] = req_b_axis_z[i*AW +: AW];
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               p1_in[i][j][k] = PW'(axa[i][k]) * PW'(axb[j][k]);
            end
         end
         for (int k = 0; k < 3; k++) begin
            tp1_in[i][k] = TPW'(DW'(cb[k]) - DW'(ca[k])) * TPW'(axa[i][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= p1_in;
         tp1_ff <= tp1_in;
         for (int i = 0; i < 3; i++) begin
            ha1_ff[i] <= req_a_half[i*CW +: CW];
            hb1_ff[i] <= req_b_half[i*CW +: CW];
         end
      end
   end

   // stage 2: dot sums
   logic signed [SW-1:0] s2_ff [3][3];
   logic signed [TW-1:0] t2_ff [3];
   logic [CW-1:0] ha2_ff [3], hb2_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               s2_ff[i][j] <= SW'(p1_ff[i][j][0]) + SW'(p1_ff[i][j][1])
                  + SW'(p1_ff[i][j][2]);
            end
            t2_ff[i] <= TW'(tp1_ff[i][0]) + TW'(tp1_ff[i][1]) + TW'(tp1_ff[i][2]);
         end
         ha2_ff <= ha1_ff;
         hb2_ff <= hb1_ff;
      end
   end

   // stage 3: round half away from zero, abs plus one lsb
   logic signed [RW-1:0] r3_in [3][3], r3_ff [3][3];
   logic signed [RW-1:0] ar3_in [3][3], ar3_ff [3][3];
   logic [SW-1:0] mag3;
   logic [SW-1:0] u3;
   always_comb begin
      mag3 = '0;
      u3 = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mag3 = s2_ff[i][j][SW-1] ? SW'(-s2_ff[i][j]) : SW'(s2_ff[i][j]);
            u3 = (mag3 + (SW'(1) << (FR-1))) >> FR;
            r3_in[i][j] = s2_ff[i][j][SW-1] ? -RW'(u3) : RW'(u3);
            ar3_in[i][j] = RW'(u3) + RW'(1);
         end
      end
   end
   logic signed [TW-1:0] t3_ff [3];
   logic [CW-1:0] ha3_ff [3], hb3_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         r3_ff <= r3_in;
         ar3_ff <= ar3_in;
         t3_ff <= t2_ff;
         ha3_ff <= ha2_ff;
         hb3_ff <= hb2_ff;
      end
   end

   // stage 4: products for projections
   logic signed [HPW-1:0] hbar4_ff [3][3], haar4_ff [3][3];
   logic signed [QPW-1:0] tr4_ff [3][3];
   logic signed [TW-1:0] t4_ff [3];
   logic [CW-1:0] ha4_ff [3], hb4_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               hbar4_ff[i][j] <= HPW'(signed'({1'b0, hb3_ff[j]})) * HPW'(ar3_ff[i][j]);
               haar4_ff[i][j] <= HPW'(signed'({1'b0, ha3_ff[i]})) * HPW'(ar3_ff[i][j]);
               tr4_ff[i][j] <= QPW'(t3_ff[i]) * QPW'(r3_ff[i][j]);
            end
         end
         t4_ff <= t3_ff;
         ha4_ff <= ha3_ff;
         hb4_ff <= hb3_ff;
      end
   end

   // stage 5: lhs and rhs of the 15 tests
   logic signed [CMPW-1:0] lhs5_in [6], rhs5_in [6], lhs5_ff [15], rhs5_ff [15];
   logic signed [CMPW-1:0] tv, rb, ra;
   always_comb begin
      tv = '0; rb = '0; ra = '0;
      for (int i = 0; i < 3; i++) begin
         tv = CMPW'(t4_ff[i]);
         rb = CMPW'(hbar4_ff[i][0]) + CMPW'(hbar4_ff[i][1]) + CMPW'(hbar4_ff[i][2]);
         lhs5_in[i] = tv < 0 ? -tv : tv;
         rhs5_in[i] = (CMPW'({1'b0, ha4_ff[i]}) <<< FR) + rb;
      end
      for (int i = 0; i < 3; i++) begin
         ra = CMPW'(haar4_ff[0][i]) + CMPW'(haar4_ff[1][i]) + CMPW'(haar4_ff[2][i]);
         tv = CMPW'(tr4_ff[0][i]) + CMPW'(tr4_ff[1][i]) + CMPW'(tr4_ff[2][i]);
         lhs5_in[3+i] = tv < 0 ? -tv : tv;
         rhs5_in[3+i] = (ra + (CMPW'({1'b0, hb4_ff[i]}) <<< FR)) <<< FR;
      end
   end

   // cross terms need ha[i1]*ar[i2][j] etc; use dedicated products
   logic signed [HPW-1:0] xa4_ff [3][3][2], xb4_ff [3][3][2];
   logic signed [QPW-1:0] xt4_ff [3][3][2];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               xa4_ff[i][j][0] <= HPW'(signed'({1'b0, ha3_ff[(i+1)%3]}))
                  * HPW'(ar3_ff[(i+2)%3][j]);
               xa4_ff[i][j][1] <= HPW'(signed'({1'b0, ha3_ff[(i+2)%3]}))
                  * HPW'(ar3_ff[(i+1)%3][j]);
               xb4_ff[i][j][0] <= HPW'(signed'({1'b0, hb3_ff[(j+1)%3]}))
                  * HPW'(ar3_ff[i][(j+2)%3]);
               xb4_ff[i][j][1] <= HPW'(signed'({1'b0, hb3_ff[(j+2)%3]}))
                  * HPW'(ar3_ff[i][(j+1)%3]);
               xt4_ff[i][j][0] <= QPW'(t3_ff[(i+2)%3]) * QPW'(r3_ff[(i+1)%3][j]);
               xt4_ff[i][j][1] <= QPW'(t3_ff[(i+1)%3]) * QPW'(r3_ff[(i+2)%3][j]);
            end
         end
      end
   end

   logic signed [CMPW-1:0] xl5_in [9], xr5_in [9], xp;
   always_comb begin
      xp = '0;
      for (int n = 0; n < 9; n++) begin
         xp = CMPW'(xt4_ff[n/3][n%3][0]) - CMPW'(xt4_ff[n/3][n%3][1]);
         xl5_in[n] = xp < 0 ? -xp : xp;
         xr5_in[n] = (CMPW'(xa4_ff[n/3][n%3][0]) + CMPW'(xa4_ff[n/3][n%3][1])
            + CMPW'(xb4_ff[n/3][n%3][0]) + CMPW'(xb4_ff[n/3][n%3][1])) <<< FR;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < 6; n++) begin
            lhs5_ff[n] <= lhs5_in[n];
            rhs5_ff[n] <= rhs5_in[n];
         end
         for (int n = 0; n < 9; n++) begin
            lhs5_ff[6+n] <= xl5_in[n];
            rhs5_ff[6+n] <= xr5_in[n];
         end
      end
   end

   // stage 6: compares
   logic [14:0] sep6_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < 15; n++) begin
            sep6_ff[n] <= lhs5_ff[n] > rhs5_ff[n];
         end
      end
   end

   // stage 7: first separating axis
   logic [SEP_W-1:0] sel7;
   always_comb begin
      sel7 = SEP_NONE;
      for (int n = 14; n >= 0; n--) begin
         if (sep6_ff[n]) begin
            sel7 = SEP_W'(n + 1);
         end
      end
   end

   logic ov_ff;
   logic [SEP_W-1:0] ax_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ov_ff <= (sel7 == SEP_NONE);
         ax_ff <= sel7;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   assign rsp_valid = vld_ff[NS-1];
   assign rsp_overlap = ov_ff;
   assign rsp_separating_axis = ax_ff;

   a_ov_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_overlap == (rsp_separating_axis == SEP_NONE)))
      else $error("overlap flag disagrees with axis code");
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_separating_axis <= SEP_W'(15)))
      else $error("axis code out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_separating_axis)))
      else $error("stalled item changed");
endmodule
`default_nettype wire
